/* src/jkse_pkg.sv */
// Shared constants, types and helper functions for the JSON key value extractor.
package jkse_pkg;

  // Default and limit for the number of key characters.
  localparam int KEY_MAX_BYTES_DEF = 16;
  localparam int KEY_CHARS_HW      = 16;

  // Largest number of result beats that one input byte can cause.
  localparam int MAX_RESULTS = 5;
  localparam int RES_IDX_W   = $clog2(MAX_RESULTS);

  // Depth of the result bundle queue (a power of two).
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes.
  localparam logic [1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_KEY_LEN  = 2'd2;

  // Status codes carried on the final beat of a text.
  localparam logic [1:0] ST_CLOSED   = 2'd0;
  localparam logic [1:0] ST_TEXT_END = 2'd1;
  localparam logic [1:0] ST_NO_KEY   = 2'd2;
  localparam logic [1:0] ST_NO_COLON = 2'd3;

  // Characters of interest.
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QMARK = 8'h3F;

  // All result beats caused by one input byte.
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [RES_IDX_W-1:0]        count;   // number of beats, 1 to MAX_RESULTS
    logic                        empty;   // single beat without a byte
    logic                        last;    // final beat of the text is in here
    logic [1:0]                  status;
  } bundle_t;

  // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

/* src/jkse_if.sv */
// Valid/ready channel interfaces for the text input and the value output.
interface jkse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface jkse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] value_byte;
  logic       has_byte;
  logic       last_of_value;
  logic [1:0] status;

  modport source (output valid, output value_byte, output has_byte,
                  output last_of_value, output status, input ready);
  modport sink   (input valid, input value_byte, input has_byte,
                  input last_of_value, input status, output ready);
endinterface

/* src/jkse_match_cell.sv */
// One cell of the key match window: holds one text byte and checks the incoming one.
module jkse_match_cell import jkse_pkg::*; #(
  parameter int KEY_MAX_BYTES = KEY_MAX_BYTES_DEF,
  parameter int IDX           = 0,
  localparam int LEN_W        = $clog2(KEY_MAX_BYTES + 1),
  localparam int KIDX_W       = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1
) (
  input  logic                           clk_i,
  input  logic                           shift_i,
  input  logic [7:0]                     byte_i,
  input  logic [LEN_W-1:0]               len_i,
  input  logic [KEY_MAX_BYTES-1:0][7:0]  key_i,
  output logic [7:0]                     byte_o,
  output logic                           hit_o
);

  logic [7:0]        byte_q;
  logic [KIDX_W-1:0] kidx;

  // The byte moves one cell further on every shift.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;

  // Window position IDX holds key character (len - IDX) once the byte arrives.
  assign kidx = KIDX_W'(len_i - LEN_W'(IDX));

  always_comb begin
    if (IDX == 0) begin
      hit_o = (byte_i == CH_QUOTE);
    end else if (int'(len_i) + 1 == IDX) begin
      hit_o = (byte_i == CH_QUOTE);
    end else if (IDX <= int'(len_i)) begin
      hit_o = (byte_i == key_i[kidx]);
    end else begin
      hit_o = 1'b1;
    end
  end

endmodule

/* src/jkse_decoder.sv */
// Phase control and string unescape; builds the result bundle for each accepted byte.
module jkse_decoder import jkse_pkg::*; #(
  parameter int KEY_MAX_BYTES = KEY_MAX_BYTES_DEF,
  localparam int LEN_W        = $clog2(KEY_MAX_BYTES + 1),
  localparam int WIN_DEPTH    = KEY_MAX_BYTES + 2,
  localparam int FILL_W       = $clog2(WIN_DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       text_byte_i,
  input  logic             end_of_text_i,
  input  logic             window_hit_i,
  input  logic [LEN_W-1:0] len_i,
  output logic             shift_o,
  output logic             push_o,
  output bundle_t          bundle_o
);

  localparam logic [2:0] PH_MATCH = 3'd0;
  localparam logic [2:0] PH_COLON = 3'd1;
  localparam logic [2:0] PH_QUOTE = 3'd2;
  localparam logic [2:0] PH_VALUE = 3'd3;
  localparam logic [2:0] PH_ESC   = 3'd4;
  localparam logic [2:0] PH_HEX   = 3'd5;
  localparam logic [2:0] PH_DONE  = 3'd6;

  logic [2:0]        ph_q, ph_d;
  logic [FILL_W-1:0] fill_q, fill_d, fill_nx;
  logic [1:0]        cnt_q, cnt_d;
  logic [15:0]       cp_q, cp_d, cp_new;
  logic [2:0][7:0]   held_q, held_d;

  logic [MAX_RESULTS-1:0][7:0] res;
  logic [RES_IDX_W-1:0]        n;
  logic                        closed, fin;
  logic [1:0]                  st;
  logic [4:0]                  hx;
  logic [7:0]                  c;

  assign c       = text_byte_i;
  assign hx      = hex_value(c);
  assign cp_new  = {cp_q[11:0], hx[3:0]};
  assign fill_nx = (fill_q == FILL_W'(WIN_DEPTH)) ? fill_q : fill_q + FILL_W'(1);
  assign shift_o = accept_i && (ph_q == PH_MATCH);

  // Next state and the result beats for the byte on the input.
  always_comb begin
    ph_d   = ph_q;
    fill_d = fill_q;
    cnt_d  = cnt_q;
    cp_d   = cp_q;
    held_d = held_q;
    res    = '0;
    n      = '0;
    closed = 1'b0;
    fin    = 1'b0;
    st     = ST_CLOSED;

    unique case (ph_q)
      PH_MATCH: begin
        fill_d = fill_nx;
        if (window_hit_i && (fill_nx >= FILL_W'(len_i) + FILL_W'(2))) begin
          ph_d = PH_COLON;
        end
      end
      PH_COLON: begin
        if (c == CH_COLON) begin
          ph_d = PH_QUOTE;
        end
      end
      PH_QUOTE: begin
        if (c == CH_QUOTE) begin
          ph_d = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (c == CH_BSLASH) begin
          ph_d = PH_ESC;
        end else if (c == CH_QUOTE) begin
          closed = 1'b1;
        end else begin
          res[n] = c;
          n      = n + RES_IDX_W'(1);
        end
      end
      PH_ESC: begin
        ph_d = PH_VALUE;
        case (c)
          8'h62: begin res[n] = 8'h08; n = n + RES_IDX_W'(1); end
          8'h66: begin res[n] = 8'h0C; n = n + RES_IDX_W'(1); end
          8'h6E: begin res[n] = 8'h0A; n = n + RES_IDX_W'(1); end
          8'h72: begin res[n] = 8'h0D; n = n + RES_IDX_W'(1); end
          8'h74: begin res[n] = 8'h09; n = n + RES_IDX_W'(1); end
          8'h75: begin
            ph_d  = PH_HEX;
            cnt_d = 2'd0;
            cp_d  = 16'd0;
          end
          default: begin res[n] = c; n = n + RES_IDX_W'(1); end
        endcase
      end
      PH_HEX: begin
        if (hx[4]) begin
          cp_d = cp_new;
          if (cnt_q == 2'd3) begin
            // Fourth digit: emit the code point as UTF-8.
            if (cp_new < 16'h0080) begin
              res[n] = cp_new[7:0];
              n      = n + RES_IDX_W'(1);
            end else if (cp_new < 16'h0800) begin
              res[n] = 8'hC0 | {3'd0, cp_new[10:6]};
              n      = n + RES_IDX_W'(1);
              res[n] = 8'h80 | {2'd0, cp_new[5:0]};
              n      = n + RES_IDX_W'(1);
            end else begin
              res[n] = 8'hE0 | {4'd0, cp_new[15:12]};
              n      = n + RES_IDX_W'(1);
              res[n] = 8'h80 | {2'd0, cp_new[11:6]};
              n      = n + RES_IDX_W'(1);
              res[n] = 8'h80 | {2'd0, cp_new[5:0]};
              n      = n + RES_IDX_W'(1);
            end
            cnt_d = 2'd0;
            ph_d  = PH_VALUE;
          end else begin
            held_d[cnt_q] = c;
            cnt_d         = cnt_q + 2'd1;
          end
        end else begin
          // Bad digit: flag it, replay held digits, then take the byte as in PH_VALUE.
          res[n] = CH_QMARK;
          n      = n + RES_IDX_W'(1);
          for (int k = 0; k < 3; k++) begin
            if (2'(k) < cnt_q) begin
              res[n] = held_q[k];
              n      = n + RES_IDX_W'(1);
            end
          end
          cnt_d = 2'd0;
          ph_d  = PH_VALUE;
          if (c == CH_BSLASH) begin
            ph_d = PH_ESC;
          end else if (c == CH_QUOTE) begin
            closed = 1'b1;
          end else begin
            res[n] = c;
            n      = n + RES_IDX_W'(1);
          end
        end
      end
      default: begin
      end
    endcase

    // Final beat and its status.
    if (closed) begin
      fin  = 1'b1;
      st   = ST_CLOSED;
      ph_d = PH_DONE;
    end else if (end_of_text_i) begin
      fin = 1'b1;
      unique case (ph_d) inside
        PH_MATCH: st = ST_NO_KEY;
        PH_COLON, PH_QUOTE: st = ST_NO_COLON;
        PH_VALUE, PH_ESC: st = ST_TEXT_END;
        PH_HEX: begin
          st     = ST_TEXT_END;
          res[n] = CH_QMARK;
          n      = n + RES_IDX_W'(1);
          for (int k = 0; k < 3; k++) begin
            if (2'(k) < cnt_d) begin
              res[n] = held_d[k];
              n      = n + RES_IDX_W'(1);
            end
          end
        end
        default: fin = 1'b0;
      endcase
    end

    // End of text rearms the key search.
    if (end_of_text_i) begin
      ph_d   = PH_MATCH;
      fill_d = '0;
      cnt_d  = 2'd0;
      cp_d   = 16'd0;
    end
  end

  // Bundle handed to the result queue.
  always_comb begin
    push_o          = accept_i && ((n != '0) || fin);
    bundle_o.bytes  = res;
    bundle_o.empty  = (n == '0);
    bundle_o.count  = (n == '0) ? RES_IDX_W'(1) : n;
    bundle_o.last   = fin;
    bundle_o.status = st;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_MATCH;
      fill_q <= '0;
      cnt_q  <= 2'd0;
      cp_q   <= 16'd0;
    end else if (accept_i) begin
      ph_q   <= ph_d;
      fill_q <= fill_d;
      cnt_q  <= cnt_d;
      cp_q   <= cp_d;
    end
  end

  // Held hex digits are only read after they have been written.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      held_q <= held_d;
    end
  end

endmodule

/* src/jkse_out_queue.sv */
// Queue of result bundles, drained one output beat per cycle while out_ch is ready.
module jkse_out_queue import jkse_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  bundle_t             bundle_i,
  output logic                full_o,
  jkse_out_if.source          out_ch
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  bundle_t              mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [RES_IDX_W-1:0] idx_q;
  bundle_t              head;
  logic                 beat, at_end, pop;

  assign head   = mem_q[rd_ptr_q];
  assign full_o = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign at_end = (idx_q == head.count - RES_IDX_W'(1));
  assign beat   = out_ch.valid && out_ch.ready;
  assign pop    = beat && at_end;

  // Output beat taken from the head bundle.
  always_comb begin
    out_ch.valid         = (cnt_q != '0);
    out_ch.value_byte    = head.empty ? 8'd0 : head.bytes[idx_q];
    out_ch.has_byte      = !head.empty;
    out_ch.last_of_value = head.last && at_end;
    out_ch.status        = (head.last && at_end) ? head.status : ST_CLOSED;
  end

  // Bundle storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= bundle_i;
    end
  end

  // Pointers, fill level and beat index within the head bundle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      idx_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= PTR_W'((int'(wr_ptr_q) + 1) % QUEUE_DEPTH);
      end
      if (pop) begin
        rd_ptr_q <= PTR_W'((int'(rd_ptr_q) + 1) % QUEUE_DEPTH);
        idx_q    <= '0;
      end else if (beat) begin
        idx_q <= idx_q + RES_IDX_W'(1);
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

/* src/json_key_string_value_extractor_unit.sv */
// Top level of the JSON key value extractor: registers, match window row, decoder, queue.
//
// Usage: JSON text enters on in_ch one byte per beat, end_of_text marking the last
// byte. The block finds the first quoted occurrence of the configured key, the next
// colon and the next quote, and sends the unescaped string value on out_ch, one byte
// per beat. The final beat of each text has last_of_value set and carries the status;
// when there is no byte to go with it, has_byte is low on that beat.
// The key is set over the APB port: key characters 0-7 at 0x00, 8-15 at 0x08 and the
// key length at 0x10. Write them only while no text is in flight.
// Throughput: one input byte per cycle while the queue is not full. The results of each
// input byte are written to the bundle queue and leave it from there. A byte that causes
// several results (a \u escape or a bad hex digit) sends one output beat per result; a
// two-entry bundle queue absorbs that, and in_ch.ready drops only when the queue is full.
// When the receiver stalls, results wait in the queue and input stops once it fills.
// Reset clears the key and control registers and restarts key search; no clearing pass.
module json_key_string_value_extractor_unit import jkse_pkg::*; #(
  parameter int KEY_MAX_BYTES = KEY_MAX_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  jkse_in_if.sink     in_ch,
  jkse_out_if.source  out_ch
);

  localparam int LEN_W     = $clog2(KEY_MAX_BYTES + 1);
  localparam int WIN_DEPTH = KEY_MAX_BYTES + 2;

  logic [63:0] key_low_q, key_high_q;
  logic [4:0]  key_len_q;
  logic        wr_en;

  logic [KEY_CHARS_HW-1:0][7:0]  key_all;
  logic [KEY_MAX_BYTES-1:0][7:0] key_chars;
  logic [LEN_W-1:0]              len;

  logic [WIN_DEPTH:0][7:0]       win_bytes;
  logic [WIN_DEPTH-1:0]          hits;
  logic                          shift, accept, push, full;
  bundle_t                       bundle;

  // Configuration registers.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= 64'd0;
      key_high_q <= 64'd0;
      key_len_q  <= 5'd0;
    end else if (wr_en) begin
      unique case (paddr[4:3])
        REG_KEY_LOW:  key_low_q  <= pwdata;
        REG_KEY_HIGH: key_high_q <= pwdata;
        REG_KEY_LEN:  key_len_q  <= pwdata[4:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_KEY_LOW:  prdata = key_low_q;
      REG_KEY_HIGH: prdata = key_high_q;
      REG_KEY_LEN:  prdata = {59'd0, key_len_q};
      default:      prdata = 64'd0;
    endcase
  end

  // Key characters in use and the clamped key length.
  assign key_all = {key_high_q, key_low_q};

  always_comb begin
    for (int k = 0; k < KEY_MAX_BYTES; k++) begin
      key_chars[k] = key_all[k];
    end
  end

  assign len = (int'(key_len_q) > KEY_MAX_BYTES) ? LEN_W'(KEY_MAX_BYTES)
                                                  : LEN_W'(key_len_q);

  // Row of match cells; the newest byte enters cell 0.
  assign win_bytes[0] = in_ch.text_byte;

  for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
    jkse_match_cell #(
      .KEY_MAX_BYTES (KEY_MAX_BYTES),
      .IDX           (i)
    ) u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .byte_i  (win_bytes[i]),
      .len_i   (len),
      .key_i   (key_chars),
      .byte_o  (win_bytes[i+1]),
      .hit_o   (hits[i])
    );
  end

  // Input handshake.
  assign in_ch.ready = !full;
  assign accept      = in_ch.valid && !full;

  jkse_decoder #(
    .KEY_MAX_BYTES (KEY_MAX_BYTES)
  ) u_decoder (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .text_byte_i   (in_ch.text_byte),
    .end_of_text_i (in_ch.end_of_text),
    .window_hit_i  (&hits),
    .len_i         (len),
    .shift_o       (shift),
    .push_o        (push),
    .bundle_o      (bundle)
  );

  jkse_out_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .bundle_i (bundle),
    .full_o   (full),
    .out_ch   (out_ch)
  );

endmodule
